>>> sv/assert_macros.svh
// assertion helpers used by bdf_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/bdf_pkg.sv
package bdf_pkg;

    localparam int TABLE_DEPTH = 1024;                  // power of two, 16 to 65536
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 64;
    localparam int HASH_W      = 16;
    localparam int Q_DEPTH     = 2;                     // power of two
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              bcast;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] bpi;
    } t_req;

    // rotate left by 3, then xor in the next byte, most significant byte first
    function automatic logic [HASH_W-1:0] bpi_hash(input logic [WORD_W-1:0] id);
        logic [HASH_W-1:0] h;
        h = '0;
        for (int k = 0; k < 8; k++) begin
            h = {h[HASH_W-4:0], h[HASH_W-1:HASH_W-3]} ^ {8'h00, id[WORD_W-1-8*k -: 8]};
        end
        return h;
    endfunction

endpackage

>>> sv/bdf_ram.sv
module bdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bdf_front.sv
module bdf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_high,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_mid,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_low,
    input  logic [bdf_pkg::WORD_W-1:0]   i_bpi,
    output logic                         o_q_full,
    output logic                         o_q_valid,
    output bdf_pkg::t_req                o_q_head,
    input  logic                         i_q_pop
);
    import bdf_pkg::*;

    t_req              n_req;
    logic [HASH_W-1:0] n_hash;
    t_req              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    // classify: broadcast when every prefix bit is set
    always_comb begin
        n_hash      = bpi_hash(i_bpi);
        n_req.bcast = (&i_prefix_high) & (&i_prefix_mid) & (&i_prefix_low);
        n_req.idx   = n_hash[IDX_W-1:0];
        n_req.bpi   = i_bpi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_accept) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_accept && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_accept && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem[r_wptr] <= n_req;
        end
    end

    assign o_q_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_head  = r_mem[r_rptr];

endmodule

>>> sv/bdf_back.sv
`include "assert_macros.svh"

module bdf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bdf_pkg::t_req i_q_head,
    output logic          o_q_pop,
    output logic          o_clearing,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_drop
);
    import bdf_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_clr_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_bpi;
    logic              r_out_valid;
    logic              r_drop;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              out_free;
    logic              hit;

    bdf_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(i_q_head.idx),
        .o_rdata(ram_rdata)
    );

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && out_free;
    assign hit      = (ram_rdata == r_bpi);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_bpi;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_LOOK: begin
                ram_we = !hit;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_idx <= i_q_head.idx;
                        r_bpi <= i_q_head.bpi;
                        if (i_q_head.bcast) begin
                            r_state     <= S_LOOK;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_drop      <= 1'b0;
                        end
                    end else if (i_pop) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_LOOK: begin
                    r_out_valid <= 1'b1;
                    r_drop      <= hit;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_drop     = r_drop;

    `ASSERT_IMPLIES(a_look_slot_free, i_clk, i_rst_n, r_state == S_LOOK, !r_out_valid)
    `ASSERT_IMPLIES(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_q_pop)
    `ASSERT_IMPLIES(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !ram_we)
    `ASSERT_NEXT(a_look_gives_result, i_clk, i_rst_n, r_state == S_LOOK, r_out_valid)

endmodule

>>> sv/broadcast_duplicate_filter.sv
// broadcast duplicate filter: each request is a 256-bit destination address
// (three prefix words plus a 64-bit broadcast identifier) and gives exactly one
// drop flag, in request order. a request whose prefix is not all ones is always
// forwarded (drop = 0) and leaves the table alone. for a broadcast the identifier
// is hashed (16-bit rotate-left-by-3 and xor over its eight bytes, msb first),
// the low bits of the hash pick an entry of a 1024-entry direct-mapped table;
// a match drops the frame, a miss overwrites the entry and forwards.
// after reset the table is swept to zero, one entry per cycle, so full stays
// high until every entry has been cleared, and only then is a request taken.
// a non-broadcast request is popped from the queue straight into the output
// register. a broadcast is popped into the registered read of the table memory,
// then compared and written back in the S_LOOK state, and its result goes into
// the output register; no new request is popped while the engine is in S_LOOK.
// a 2-deep request queue sits between the classify/hash front and the table
// engine, and the result is held in an output register, so push and pop
// stall independently.
module broadcast_duplicate_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_high,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_mid,
    input  logic [bdf_pkg::WORD_W-1:0]   i_prefix_low,
    input  logic [bdf_pkg::WORD_W-1:0]   i_bpi,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_drop
);
    import bdf_pkg::*;

    logic q_full;
    logic q_valid;
    logic q_pop;
    t_req q_head;
    logic clearing;
    logic accept;

    // no requests taken while the table clear sweep runs
    assign full   = q_full || clearing;
    assign accept = push && !full;

    // front: classify, hash and queue the request
    bdf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_prefix_high(i_prefix_high),
        .i_prefix_mid (i_prefix_mid),
        .i_prefix_low (i_prefix_low),
        .i_bpi        (i_bpi),
        .o_q_full     (q_full),
        .o_q_valid    (q_valid),
        .o_q_head     (q_head),
        .i_q_pop      (q_pop)
    );

    // back: table lookup and update, result register
    bdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_clearing(clearing),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_drop    (o_drop)
    );

endmodule
